// ===== rtl/char_lcd_nibble_interface_macros.svh =====
// Assertion macros shared by the character LCD interface RTL.
`ifndef CHAR_LCD_NIBBLE_INTERFACE_MACROS_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_MACROS_SVH

// Check a same-cycle implication on clk, disabled while in reset.
`define CLNI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a next-cycle implication on clk, disabled while in reset.
`define CLNI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/clni_pkg.sv =====
// Types, constants and sequencing functions of the character LCD interface.
package clni_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP_WAIT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_GAP           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ENABLE_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ENABLE_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_WAIT        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_WAIT         = 3'd5;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_POWER_UP_WAIT      = 16'd30000;
  localparam logic [CFG_W-1:0] RST_INIT_GAP           = 16'd50;
  localparam logic [CFG_W-1:0] RST_FIRST_ENABLE_HIGH  = 16'd1000;
  localparam logic [CFG_W-1:0] RST_SECOND_ENABLE_HIGH = 16'd2;
  localparam logic [CFG_W-1:0] RST_SETTLE_WAIT        = 16'd40;
  localparam logic [CFG_W-1:0] RST_CLEAR_WAIT         = 16'd2000;

  // Request codes
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_CURSOR  = 2'd2;
  localparam logic [1:0] CMD_RESTART = 2'd3;

  // Init sequence bounds and fixed instruction values
  localparam logic [3:0] INIT_NIBBLES = 4'd12;
  localparam logic [3:0] INIT_DONE    = 4'd15;
  localparam logic [7:0] INSTR_CLEAR  = 8'h01;
  localparam logic [7:0] INSTR_DISP   = 8'h0C;
  localparam logic [7:0] INSTR_ENTRY  = 8'h06;
  localparam logic [7:0] DDRAM_SET    = 8'h80;
  localparam logic [7:0] ROW_ODD_OFS  = 8'h40;
  localparam logic [7:0] ROW_HIGH_OFS = 8'h14;

  typedef enum logic [2:0] {
    PH_POWER,
    PH_INIT_EN,
    PH_INIT_GAP,
    PH_XFER_EN,
    PH_XFER_SET,
    PH_CLEAR,
    PH_IDLE
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] held_byte;
    logic       held_select;
    logic [3:0] init_step;
    logic [3:0] nibble;
    logic       enable;
    logic       low_half;
  } lcd_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] power_up_wait;
    logic [CFG_W-1:0] init_gap;
    logic [CFG_W-1:0] first_enable_high;
    logic [CFG_W-1:0] second_enable_high;
    logic [CFG_W-1:0] settle_wait;
    logic [CFG_W-1:0] clear_wait;
  } lcd_cfg_t;

  // Waits that are skipped at once when programmed to zero
  typedef struct packed {
    logic power;
    logic settle;
    logic clear;
  } zero_wait_t;

  typedef struct packed {
    logic [3:0] bus_nibble;
    logic       enable_pin;
    logic       select_pin;
    logic       busy_res;
    logic       rejected;
  } lcd_result_t;

  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] n;
    case (idx)
      4'd0, 4'd1, 4'd2: n = 4'd3;
      4'd3, 4'd4:       n = 4'd2;
      4'd5, 4'd7:       n = 4'd8;
      4'd9:             n = 4'd1;
      4'd11:            n = 4'd6;
      4'd12, 4'd13, 4'd14: n = 4'd3;
      4'd15:            n = 4'd2;
      default:          n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] post_byte(input logic [3:0] step);
    logic [7:0] b;
    case (step)
      4'd13:   b = INSTR_CLEAR;
      4'd14:   b = INSTR_ENTRY;
      default: b = INSTR_DISP;
    endcase
    return b;
  endfunction

  function automatic lcd_state_t restart_state();
    lcd_state_t r;
    r.phase       = PH_POWER;
    r.held_byte   = '0;
    r.held_select = 1'b0;
    r.init_step   = '0;
    r.nibble      = '0;
    r.enable      = 1'b1;
    r.low_half    = 1'b0;
    return r;
  endfunction

  function automatic lcd_state_t start_byte(input lcd_state_t s, input logic [7:0] b,
                                            input logic sel);
    lcd_state_t r;
    r             = s;
    r.held_byte   = b;
    r.held_select = sel;
    r.low_half    = 1'b0;
    r.nibble      = b[7:4];
    r.enable      = 1'b1;
    r.phase       = PH_XFER_EN;
    return r;
  endfunction

  function automatic lcd_state_t finish_byte(input lcd_state_t s);
    lcd_state_t r;
    r       = s;
    r.phase = PH_IDLE;
    // Step through the post-init instructions
    if (s.init_step >= INIT_NIBBLES && s.init_step < INIT_DONE) begin
      r.init_step = s.init_step + 4'd1;
      if (r.init_step < INIT_DONE) begin
        r = start_byte(r, post_byte(r.init_step), 1'b0);
      end
    end
    return r;
  endfunction

  function automatic lcd_state_t transition(input lcd_state_t s);
    lcd_state_t r;
    logic [4:0] step_inc;
    r        = s;
    step_inc = {1'b0, s.init_step} + 5'd1;
    case (s.phase)
      PH_POWER: begin
        r.nibble = init_nibble(s.init_step);
        r.enable = 1'b1;
        r.phase  = PH_INIT_EN;
      end
      PH_INIT_EN: begin
        r.enable = 1'b0;
        r.phase  = PH_INIT_GAP;
      end
      PH_INIT_GAP: begin
        if (step_inc < {1'b0, INIT_NIBBLES}) begin
          r.init_step = step_inc[3:0];
          r.nibble    = init_nibble(step_inc[3:0]);
          r.enable    = 1'b1;
          r.phase     = PH_INIT_EN;
        end else begin
          r.init_step = INIT_NIBBLES;
          r = start_byte(r, INSTR_DISP, 1'b0);
        end
      end
      PH_XFER_EN: begin
        r.enable = 1'b0;
        r.phase  = PH_XFER_SET;
      end
      PH_XFER_SET: begin
        if (!s.low_half) begin
          r.low_half = 1'b1;
          r.nibble   = s.held_byte[3:0];
          r.enable   = 1'b1;
          r.phase    = PH_XFER_EN;
        end else if (!s.held_select && s.held_byte == INSTR_CLEAR) begin
          r.phase = PH_CLEAR;
        end else begin
          r = finish_byte(s);
        end
      end
      PH_CLEAR: r = finish_byte(s);
      default:  r.phase = PH_IDLE;
    endcase
    return r;
  endfunction

  function automatic logic zero_wait(input lcd_state_t s, input zero_wait_t z);
    return (s.phase == PH_POWER && z.power) || (s.phase == PH_XFER_SET && z.settle) ||
           (s.phase == PH_CLEAR && z.clear);
  endfunction

  // Move on one phase, then skip up to two phases whose wait is zero
  function automatic lcd_state_t advance(input lcd_state_t s, input zero_wait_t z);
    lcd_state_t r;
    r = transition(s);
    for (int i = 0; i < 2; i++) begin
      if (r.phase != PH_IDLE && zero_wait(r, z)) begin
        r = transition(r);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/clni_step.sv =====
// Next-state and result logic for one tick or request of the LCD interface.
module clni_step #(
  parameter int TIMER_BITS = 16
) (
  input  clni_pkg::lcd_state_t  state,
  input  logic [TIMER_BITS-1:0] wait_count,
  input  clni_pkg::lcd_cfg_t    cfg,
  input  logic [1:0]            command,
  input  logic [7:0]            byte_value,
  input  logic                  register_select,
  input  logic [5:0]            column,
  input  logic [1:0]            row,
  output clni_pkg::lcd_state_t  state_nxt,
  output logic [TIMER_BITS-1:0] wait_nxt,
  output clni_pkg::lcd_result_t result
);

  localparam int CW = (TIMER_BITS > clni_pkg::CFG_W) ? TIMER_BITS : clni_pkg::CFG_W;
  localparam logic [CW-1:0] TIMER_MAX = {CW{1'b1}} >> (CW - TIMER_BITS);

  logic [clni_pkg::CFG_W-1:0] dur_raw;
  logic [CW-1:0]              dur_ext;
  logic [CW-1:0]              dur_sat;
  logic [TIMER_BITS-1:0]      wait_inc;
  logic                       busy;
  logic                       rejected;
  logic [7:0]                 cursor_addr;
  clni_pkg::zero_wait_t       zw;

  // Pick the length of the current phase
  always_comb begin
    case (state.phase)
      clni_pkg::PH_POWER:    dur_raw = cfg.power_up_wait;
      clni_pkg::PH_INIT_GAP: dur_raw = (cfg.init_gap == '0) ? 16'd1 : cfg.init_gap;
      clni_pkg::PH_XFER_EN: begin
        if (state.low_half) begin
          dur_raw = (cfg.second_enable_high == '0) ? 16'd1 : cfg.second_enable_high;
        end else begin
          dur_raw = (cfg.first_enable_high == '0) ? 16'd1 : cfg.first_enable_high;
        end
      end
      clni_pkg::PH_XFER_SET: dur_raw = cfg.settle_wait;
      clni_pkg::PH_CLEAR:    dur_raw = cfg.clear_wait;
      default:               dur_raw = 16'd1;
    endcase
  end

  // Saturate to the timer width
  assign dur_ext  = CW'(dur_raw);
  assign dur_sat  = (dur_ext > TIMER_MAX) ? TIMER_MAX : dur_ext;
  assign wait_inc = wait_count + 1'b1;
  assign busy     = state.phase != clni_pkg::PH_IDLE;

  assign zw.power  = cfg.power_up_wait == '0;
  assign zw.settle = cfg.settle_wait == '0;
  assign zw.clear  = cfg.clear_wait == '0;

  assign cursor_addr = ((row[0] ? clni_pkg::ROW_ODD_OFS : 8'd0) +
                        (row[1] ? clni_pkg::ROW_HIGH_OFS : 8'd0) + {2'b00, column}) |
                       clni_pkg::DDRAM_SET;

  // Apply the tick or request
  always_comb begin
    state_nxt = state;
    wait_nxt  = wait_count;
    rejected  = 1'b0;
    case (command)
      clni_pkg::CMD_TICK: begin
        if (busy) begin
          if (CW'(wait_inc) >= dur_sat) begin
            state_nxt = clni_pkg::advance(state, zw);
            wait_nxt  = '0;
          end else begin
            wait_nxt = wait_inc;
          end
        end
      end
      clni_pkg::CMD_RESTART: begin
        state_nxt = clni_pkg::restart_state();
        wait_nxt  = '0;
        if (zw.power) begin
          state_nxt = clni_pkg::advance(clni_pkg::restart_state(), zw);
        end
      end
      clni_pkg::CMD_WRITE: begin
        if (busy) begin
          rejected = 1'b1;
        end else begin
          state_nxt = clni_pkg::start_byte(state, byte_value, register_select);
          wait_nxt  = '0;
        end
      end
      default: begin
        if (busy) begin
          rejected = 1'b1;
        end else begin
          state_nxt = clni_pkg::start_byte(state, cursor_addr, 1'b0);
          wait_nxt  = '0;
        end
      end
    endcase
  end

  assign result.bus_nibble = state_nxt.nibble;
  assign result.enable_pin = state_nxt.enable;
  assign result.select_pin = state_nxt.held_select;
  assign result.busy_res   = state_nxt.phase != clni_pkg::PH_IDLE;
  assign result.rejected   = rejected;

endmodule

// ===== rtl/clni_out_reg.sv =====
// Result register with valid/stall handshake for the LCD interface.
module clni_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  in_fire,
  input  clni_pkg::lcd_result_t res_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output clni_pkg::lcd_result_t res_out
);

  logic                  valid_r;
  logic                  valid_nxt;
  clni_pkg::lcd_result_t res_r;

  // Stall the input during reset and while a result waits and is itself stalled
  assign in_stall  = !rst_n || (valid_r && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign valid_nxt = in_fire ? 1'b1 : (valid_r && out_stall);

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load the result on each accepted transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

// ===== rtl/char_lcd_nibble_interface.sv =====
// Top level of the 4-bit character LCD interface: state, registers and result port.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  command, byte_value, register_select, column, row
//   out      output     out_valid/out_stall bus_nibble, enable_pin, select_pin, busy_res,
//                                           rejected
//   cfg      input      cfg_we             cfg_index, cfg_wdata (six 16-bit registers)
//
// One transaction is accepted in every cycle unless the input stalls; the state update
// and the result both come from a single combinational pass into registers.
// A result is registered and appears in the cycle after its transaction is accepted.
// The input stalls only during reset or while a result is held and the output side stalls.
// Synchronous reset starts the power-up wait and loads the register defaults.
`include "char_lcd_nibble_interface_macros.svh"

module char_lcd_nibble_interface #(
  parameter int TIMER_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_command,
  input  logic [7:0]                      in_byte_value,
  input  logic                            in_register_select,
  input  logic [5:0]                      in_column,
  input  logic [1:0]                      in_row,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [3:0]                      out_bus_nibble,
  output logic                            out_enable_pin,
  output logic                            out_select_pin,
  output logic                            out_busy_res,
  output logic                            out_rejected,
  input  logic                            cfg_we,
  input  logic [clni_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clni_pkg::CFG_W-1:0]      cfg_wdata
);

  clni_pkg::lcd_state_t  state_r;
  clni_pkg::lcd_state_t  state_nxt;
  logic [TIMER_BITS-1:0] wait_r;
  logic [TIMER_BITS-1:0] wait_nxt;
  clni_pkg::lcd_cfg_t    cfg_r;
  clni_pkg::lcd_result_t step_res;
  clni_pkg::lcd_result_t out_res;
  logic                  in_fire;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_up_wait      <= clni_pkg::RST_POWER_UP_WAIT;
      cfg_r.init_gap           <= clni_pkg::RST_INIT_GAP;
      cfg_r.first_enable_high  <= clni_pkg::RST_FIRST_ENABLE_HIGH;
      cfg_r.second_enable_high <= clni_pkg::RST_SECOND_ENABLE_HIGH;
      cfg_r.settle_wait        <= clni_pkg::RST_SETTLE_WAIT;
      cfg_r.clear_wait         <= clni_pkg::RST_CLEAR_WAIT;
    end else if (cfg_we) begin
      case (cfg_index)
        clni_pkg::CFG_POWER_UP_WAIT:      cfg_r.power_up_wait      <= cfg_wdata;
        clni_pkg::CFG_INIT_GAP:           cfg_r.init_gap           <= cfg_wdata;
        clni_pkg::CFG_FIRST_ENABLE_HIGH:  cfg_r.first_enable_high  <= cfg_wdata;
        clni_pkg::CFG_SECOND_ENABLE_HIGH: cfg_r.second_enable_high <= cfg_wdata;
        clni_pkg::CFG_SETTLE_WAIT:        cfg_r.settle_wait        <= cfg_wdata;
        clni_pkg::CFG_CLEAR_WAIT:         cfg_r.clear_wait         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  clni_step #(
    .TIMER_BITS(TIMER_BITS)
  ) u_step (
    .state          (state_r),
    .wait_count     (wait_r),
    .cfg            (cfg_r),
    .command        (in_command),
    .byte_value     (in_byte_value),
    .register_select(in_register_select),
    .column         (in_column),
    .row            (in_row),
    .state_nxt      (state_nxt),
    .wait_nxt       (wait_nxt),
    .result         (step_res)
  );

  // Advance sequencer state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clni_pkg::restart_state();
      wait_r  <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
    end
  end

  clni_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_fire  (in_fire),
    .res_in   (step_res),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .res_out  (out_res)
  );

  assign out_bus_nibble = out_res.bus_nibble;
  assign out_enable_pin = out_res.enable_pin;
  assign out_select_pin = out_res.select_pin;
  assign out_busy_res   = out_res.busy_res;
  assign out_rejected   = out_res.rejected;

  // Enable is low once a transfer has finished
  `CLNI_ASSERT_IMP(a_idle_enable_low, state_r.phase == clni_pkg::PH_IDLE, !state_r.enable,
                   "enable high while idle")
  // Enable is high during every enable phase
  `CLNI_ASSERT_IMP(a_enable_phase_high,
                   state_r.phase == clni_pkg::PH_INIT_EN || state_r.phase == clni_pkg::PH_XFER_EN,
                   state_r.enable, "enable low during enable phase")
  // Restart lands in the power-up wait or the first init nibble
  `CLNI_ASSERT_NXT(a_restart_phase, in_fire && in_command == clni_pkg::CMD_RESTART,
                   state_r.phase == clni_pkg::PH_POWER || state_r.phase == clni_pkg::PH_INIT_EN,
                   "restart did not reach init")
  // A request while busy is flagged in its result
  `CLNI_ASSERT_NXT(a_busy_reject,
                   in_fire && state_r.phase != clni_pkg::PH_IDLE &&
                   (in_command == clni_pkg::CMD_WRITE || in_command == clni_pkg::CMD_CURSOR),
                   out_valid && out_res.rejected, "busy request not rejected")

endmodule
